// ===== hdl/line_follower_pd_drive_macros.svh =====
// -----------------------------------------------------------------------------
// line_follower_pd_drive_macros.svh
// Assertion macros shared by the line follower drive RTL. Each macro samples
// on i_clk and is disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_PD_DRIVE_MACROS_SVH
`define LINE_FOLLOWER_PD_DRIVE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define LFPD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define LFPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define LFPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/lfpd_pkg.sv =====
// -----------------------------------------------------------------------------
// lfpd_pkg
// Types, register map, reset values and helper functions of the PD line
// follower motor drive.
// -----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DIV_STEPS = 19;
    localparam int unsigned CNT_W     = 5;

    localparam logic [7:0]  PROP_GAIN_RST     = 8'd130;
    localparam logic [7:0]  DERIV_GAIN_RST    = 8'd60;
    localparam logic [7:0]  BASE_RIGHT_RST    = 8'd155;
    localparam logic [7:0]  BASE_LEFT_RST     = 8'd155;
    localparam logic [7:0]  MAX_SPEED_RST     = 8'd230;
    localparam logic [15:0] UPDATE_PERIOD_RST = 16'd100;

    typedef struct packed {
        logic [4:0]  sensor_bits;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] speed_right;
        logic [7:0] speed_left;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_DERIV_GAIN    = 3'd1,
        REG_BASE_RIGHT    = 3'd2,
        REG_BASE_LEFT     = 3'd3,
        REG_MAX_SPEED     = 3'd4,
        REG_UPDATE_PERIOD = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_COMMIT,
        S_MULTIPLY,
        S_TERM,
        S_CLAMP
    } t_state;

    localparam logic signed [3:0] ERR_CENTRE      = 4'sd0;
    localparam logic signed [3:0] ERR_RIGHT       = 4'sd1;
    localparam logic signed [3:0] ERR_LEFT        = -4'sd1;
    localparam logic signed [3:0] ERR_OUTER_LEFT  = -4'sd2;
    localparam logic signed [3:0] ERR_OUTER_RIGHT = 4'sd2;
    localparam logic signed [3:0] ERR_LOST        = 4'sd4;

    // Priority order: centre, right, left, outer left, outer right.
    function automatic logic signed [3:0] encode_error(input logic [4:0] bits);
        logic signed [3:0] err;
        if (bits[2]) begin
            err = ERR_CENTRE;
        end else if (bits[1]) begin
            err = ERR_RIGHT;
        end else if (bits[3]) begin
            err = ERR_LEFT;
        end else if (bits[4]) begin
            err = ERR_OUTER_LEFT;
        end else if (bits[0]) begin
            err = ERR_OUTER_RIGHT;
        end else begin
            err = ERR_LOST;
        end
        return err;
    endfunction

    // Floors a Q16 speed and clamps it to 0..max.
    function automatic logic [7:0] clamp_speed(input logic signed [35:0] q16,
                                               input logic [7:0] max);
        logic [7:0] v;
        if (q16[35]) begin
            v = 8'd0;
        end else if (q16[35:16] > {12'd0, max}) begin
            v = max;
        end else begin
            v = q16[23:16];
        end
        return v;
    endfunction

endpackage

// ===== hdl/line_follower_pd_drive.sv =====
// -----------------------------------------------------------------------------
// line_follower_pd_drive
// PD motor drive for a five-sensor line follower with an iterative divider.
// -----------------------------------------------------------------------------
// Each input word carries the five sensor bits and a millisecond timestamp and
// yields exactly one output word with the right and left motor speeds.
// A word is taken when i_in_valid is high and o_in_stall is low; the result
// is offered with o_out_valid and is held until i_out_stall is low.
// o_in_stall stays high from acceptance until the result has been loaded into
// the output register, so one word is in flight at a time.
// After acceptance a word passes S_CHECK, then, when the error rate is
// refreshed (elapsed time above the update period), the restoring divider
// and S_COMMIT, and then S_MULTIPLY, S_TERM and S_CLAMP. The divider
// retires one quotient bit per cycle, 19 bits in all, using one shared
// compare-and-subtract unit. The next word can be taken in the cycle after
// the result is loaded, while that result still waits in the output
// register. If the receiver stalls and the output register is full, the
// finished result waits in the last step and the input stays stalled.
// Reset is synchronous and active low: the configuration registers return to
// their defaults and the timestamp, previous error and error rate clear.
// Configuration is an APB-style port; pready is always high.
// -----------------------------------------------------------------------------
module line_follower_pd_drive (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lfpd_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lfpd_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfpd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    `include "line_follower_pd_drive_macros.svh"

    lfpd_pkg::t_state r_state, n_state;

    logic [7:0]  r_prop_gain, r_deriv_gain, r_base_right, r_base_left, r_max_speed;
    logic [15:0] r_update_period;

    logic [31:0]        r_last_time;
    logic signed [3:0]  r_prev_err;
    logic signed [23:0] r_error_rate;

    logic signed [3:0]  r_err;
    logic [31:0]        r_time;
    logic [31:0]        r_elapsed;
    logic               r_neg;
    logic [18:0]        r_rem;
    logic [18:0]        r_quo;
    logic [lfpd_pkg::CNT_W-1:0] r_count;
    logic signed [32:0] r_prod_d;
    logic signed [12:0] r_prod_p;
    logic signed [35:0] r_term;

    logic                r_out_valid;
    lfpd_pkg::t_out_item r_out_data;

    logic               w_accept;
    logic               w_cfg_write;
    logic               w_update;
    logic               w_out_free;
    logic               w_load_out;
    logic [19:0]        w_rem_shift;
    logic               w_rem_ge;
    logic [19:0]        w_rem_diff;
    logic signed [4:0]  w_diff;
    logic [2:0]         w_mag;
    logic signed [35:0] w_right, w_left;
    lfpd_pkg::t_reg_idx w_reg;

    assign w_reg       = lfpd_pkg::t_reg_idx'(paddr[4:2]);
    assign w_cfg_write = psel && penable && pwrite;
    assign pready      = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= lfpd_pkg::PROP_GAIN_RST;
            r_deriv_gain    <= lfpd_pkg::DERIV_GAIN_RST;
            r_base_right    <= lfpd_pkg::BASE_RIGHT_RST;
            r_base_left     <= lfpd_pkg::BASE_LEFT_RST;
            r_max_speed     <= lfpd_pkg::MAX_SPEED_RST;
            r_update_period <= lfpd_pkg::UPDATE_PERIOD_RST;
        end else if (w_cfg_write) begin
            case (w_reg)
                lfpd_pkg::REG_PROP_GAIN:     r_prop_gain     <= pwdata[7:0];
                lfpd_pkg::REG_DERIV_GAIN:    r_deriv_gain    <= pwdata[7:0];
                lfpd_pkg::REG_BASE_RIGHT:    r_base_right    <= pwdata[7:0];
                lfpd_pkg::REG_BASE_LEFT:     r_base_left     <= pwdata[7:0];
                lfpd_pkg::REG_MAX_SPEED:     r_max_speed     <= pwdata[7:0];
                lfpd_pkg::REG_UPDATE_PERIOD: r_update_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            lfpd_pkg::REG_PROP_GAIN:     prdata = {24'd0, r_prop_gain};
            lfpd_pkg::REG_DERIV_GAIN:    prdata = {24'd0, r_deriv_gain};
            lfpd_pkg::REG_BASE_RIGHT:    prdata = {24'd0, r_base_right};
            lfpd_pkg::REG_BASE_LEFT:     prdata = {24'd0, r_base_left};
            lfpd_pkg::REG_MAX_SPEED:     prdata = {24'd0, r_max_speed};
            lfpd_pkg::REG_UPDATE_PERIOD: prdata = {16'd0, r_update_period};
            default:                     prdata = 32'd0;
        endcase
    end

    // Shared compare-and-subtract unit of the restoring divider.
    assign w_rem_shift = {r_rem, r_quo[18]};
    assign w_rem_ge    = {12'd0, w_rem_shift} >= r_elapsed;
    assign w_rem_diff  = w_rem_shift - r_elapsed[19:0];

    assign w_update = r_elapsed > {16'd0, r_update_period};
    assign w_diff   = 5'(r_err) - 5'(r_prev_err);
    assign w_mag    = w_diff[4] ? 3'(-w_diff) : w_diff[2:0];

    assign w_right = $signed({12'd0, r_base_right, 16'd0}) + r_term;
    assign w_left  = $signed({12'd0, r_base_left, 16'd0}) - r_term;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfpd_pkg::S_IDLE:     if (i_in_valid) n_state = lfpd_pkg::S_CHECK;
            lfpd_pkg::S_CHECK:    n_state = w_update ? lfpd_pkg::S_DIVIDE
                                                     : lfpd_pkg::S_MULTIPLY;
            lfpd_pkg::S_DIVIDE: begin
                if (r_count == lfpd_pkg::CNT_W'(lfpd_pkg::DIV_STEPS - 1)) begin
                    n_state = lfpd_pkg::S_COMMIT;
                end
            end
            lfpd_pkg::S_COMMIT:   n_state = lfpd_pkg::S_MULTIPLY;
            lfpd_pkg::S_MULTIPLY: n_state = lfpd_pkg::S_TERM;
            lfpd_pkg::S_TERM:     n_state = lfpd_pkg::S_CLAMP;
            lfpd_pkg::S_CLAMP:    if (w_out_free) n_state = lfpd_pkg::S_IDLE;
            default:              n_state = lfpd_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        w_load_out = 1'b0;
        case (r_state)
            lfpd_pkg::S_IDLE:  o_in_stall = 1'b0;
            lfpd_pkg::S_CLAMP: w_load_out = w_out_free;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lfpd_pkg::S_IDLE;
            r_last_time  <= 32'd0;
            r_prev_err   <= 4'sd0;
            r_error_rate <= 24'sd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lfpd_pkg::S_COMMIT) begin
                r_error_rate <= r_neg ? -$signed({5'd0, r_quo}) : $signed({5'd0, r_quo});
                r_last_time  <= r_time;
                r_prev_err   <= r_err;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err     <= lfpd_pkg::encode_error(i_in_data.sensor_bits);
            r_time    <= i_in_data.time_ms;
            r_elapsed <= i_in_data.time_ms - r_last_time;
        end
        case (r_state)
            lfpd_pkg::S_CHECK: begin
                r_neg   <= w_diff[4];
                r_quo   <= {w_mag, 16'd0};
                r_rem   <= 19'd0;
                r_count <= '0;
            end
            lfpd_pkg::S_DIVIDE: begin
                // The dividend shifts out of the top of r_quo as quotient bits
                // shift in at the bottom.
                r_rem   <= w_rem_ge ? w_rem_diff[18:0] : w_rem_shift[18:0];
                r_quo   <= {r_quo[17:0], w_rem_ge};
                r_count <= r_count + 1'b1;
            end
            lfpd_pkg::S_MULTIPLY: begin
                r_prod_d <= $signed({1'b0, r_deriv_gain}) * r_error_rate;
                r_prod_p <= $signed({1'b0, r_prop_gain}) * r_err;
            end
            lfpd_pkg::S_TERM: begin
                r_term <= $signed({{3{r_prod_d[32]}}, r_prod_d})
                        + $signed({{7{r_prod_p[12]}}, r_prod_p, 16'd0});
            end
            default: ;
        endcase
        if (w_load_out) begin
            r_out_data.speed_right <= lfpd_pkg::clamp_speed(w_right, r_max_speed);
            r_out_data.speed_left  <= lfpd_pkg::clamp_speed(w_left, r_max_speed);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `LFPD_ASSERT_NEXT(a_accept_starts, w_accept, r_state == lfpd_pkg::S_CHECK,
        "Accepted word did not start a computation")
    `LFPD_ASSERT_SAME(a_rem_below_divisor, r_state == lfpd_pkg::S_DIVIDE,
        r_elapsed > 32'(r_rem), "Divider remainder not below divisor")
    `LFPD_ASSERT_NEXT(a_result_presented, w_load_out, o_out_valid,
        "Finished result was not presented")
    `LFPD_ASSERT_ALWAYS(a_rate_range,
        (r_error_rate <= 24'sd393216) && (r_error_rate >= -24'sd393216),
        "Error rate beyond the largest error step")

endmodule

// ===== verif/line_follower_pd_drive_tb.sv =====
// -----------------------------------------------------------------------------
// line_follower_pd_drive_tb
// Self-checking bench for the PD line follower motor drive. A queue of sensor
// words is driven through the valid/stall input while the output side stalls
// at random. A behavioural predictor works out the expected motor speeds for
// each accepted word, and every result word is checked against it. Register
// settings change between phases through the APB-style port.
// -----------------------------------------------------------------------------
module line_follower_pd_drive_tb;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        in_valid;
    logic                        o_in_stall;
    lfpd_pkg::t_in_item          in_data;
    logic                        o_out_valid;
    logic                        out_stall;
    lfpd_pkg::t_out_item         o_out_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lfpd_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    line_follower_pd_drive u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Register copies held by the bench.
    logic [7:0]  cfg_prop;
    logic [7:0]  cfg_deriv;
    logic [7:0]  cfg_base_right;
    logic [7:0]  cfg_base_left;
    logic [7:0]  cfg_max;
    logic [15:0] cfg_period;

    // Predictor state.
    logic [31:0] last_refresh_ms;
    int          latched_error;
    longint      error_slope_q16;

    lfpd_pkg::t_in_item  pending_samples[$];
    lfpd_pkg::t_out_item expected_speeds[$];

    logic        in_fire;
    logic        idle_on;
    int          in_gap;
    int          stall_left;
    int          hold_left;
    logic        hold_done;
    logic [31:0] next_stamp;

    int          samples_accepted;
    int          pairs_checked;
    int          rate_refreshes;
    int          settings_used;
    int          mismatches;

    logic [4:0]  line_shapes [10] = '{5'b00100, 5'b00110, 5'b01100, 5'b00010, 5'b01000,
                                      5'b10000, 5'b00001, 5'b11000, 5'b00011, 5'b00000};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Position error from the sensor bits, centre taking priority.
    function automatic int line_position(input logic [4:0] bits);
        int pos;
        casez (bits)
            5'b??1??: pos = 0;
            5'b???1?: pos = 1;
            5'b?1?0?: pos = -1;
            5'b10000, 5'b10001: pos = -2;
            5'b00001: pos = 2;
            default:  pos = 4;
        endcase
        return pos;
    endfunction

    function automatic logic [7:0] floor_and_clamp(input longint q16);
        longint whole;
        if (q16 < 0) begin
            return 8'd0;
        end
        whole = q16 >>> 16;
        if (whole > longint'(cfg_max)) begin
            return cfg_max;
        end
        return whole[7:0];
    endfunction

    // Advances the predictor by one sensor word and returns the speed pair.
    function automatic lfpd_pkg::t_out_item predict_speeds(input lfpd_pkg::t_in_item sample);
        lfpd_pkg::t_out_item pair;
        int                  pos;
        logic [31:0]         elapsed;
        longint              diff;
        longint              quot;
        longint              term;
        pos = line_position(sample.sensor_bits);
        elapsed = sample.time_ms - last_refresh_ms;
        if (elapsed > {16'd0, cfg_period}) begin
            diff = longint'(pos - latched_error);
            quot = ((diff < 0) ? -diff : diff) * 65536 / longint'(elapsed);
            error_slope_q16 = (diff < 0) ? -quot : quot;
            last_refresh_ms = sample.time_ms;
            latched_error = pos;
            rate_refreshes++;
        end
        term = longint'(cfg_deriv) * error_slope_q16
             + longint'(cfg_prop) * longint'(pos) * 65536;
        pair.speed_right = floor_and_clamp(longint'(cfg_base_right) * 65536 + term);
        pair.speed_left  = floor_and_clamp(longint'(cfg_base_left) * 65536 - term);
        return pair;
    endfunction

    // Mostly short gaps, now and then a long one, and none at all while idle_on is low.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 80);
    endfunction

    // Input side: a new word is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end else if (pending_samples.size() > 0) begin
                in_data  <= pending_samples.pop_front();
                in_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side stalls, with one long hold-off once the run is well under way.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (!hold_done && samples_accepted >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            out_stall <= 1'b0;
            stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin : check_words
        lfpd_pkg::t_out_item want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) begin
                expected_speeds.push_back(predict_speeds(in_data));
                samples_accepted++;
            end
            if (o_out_valid && !out_stall) begin
                if (expected_speeds.size() == 0) begin
                    $error("speed word with none expected: right %0d left %0d",
                           o_out_data.speed_right, o_out_data.speed_left);
                    mismatches++;
                end else begin
                    want = expected_speeds.pop_front();
                    pairs_checked++;
                    if (o_out_data.speed_right !== want.speed_right) begin
                        $error("speed_right: expected %0d, got %0d",
                               want.speed_right, o_out_data.speed_right);
                        mismatches++;
                    end
                    if (o_out_data.speed_left !== want.speed_left) begin
                        $error("speed_left: expected %0d, got %0d",
                               want.speed_left, o_out_data.speed_left);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input lfpd_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lfpd_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            lfpd_pkg::REG_PROP_GAIN:     cfg_prop       = value[7:0];
            lfpd_pkg::REG_DERIV_GAIN:    cfg_deriv      = value[7:0];
            lfpd_pkg::REG_BASE_RIGHT:    cfg_base_right = value[7:0];
            lfpd_pkg::REG_BASE_LEFT:     cfg_base_left  = value[7:0];
            lfpd_pkg::REG_MAX_SPEED:     cfg_max        = value[7:0];
            lfpd_pkg::REG_UPDATE_PERIOD: cfg_period     = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_drive(input int prop, input int deriv, input int right,
                                 input int left, input int top, input int period);
        write_reg(lfpd_pkg::REG_PROP_GAIN, prop);
        write_reg(lfpd_pkg::REG_DERIV_GAIN, deriv);
        write_reg(lfpd_pkg::REG_BASE_RIGHT, right);
        write_reg(lfpd_pkg::REG_BASE_LEFT, left);
        write_reg(lfpd_pkg::REG_MAX_SPEED, top);
        write_reg(lfpd_pkg::REG_UPDATE_PERIOD, period);
        settings_used++;
    endtask

    // Lets the drive empty out before registers are touched.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_valid || expected_speeds.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic push_sample(input logic [4:0] bits, input logic [31:0] stamp);
        lfpd_pkg::t_in_item s;
        s.sensor_bits = bits;
        s.time_ms     = stamp;
        pending_samples.push_back(s);
        next_stamp = stamp;
    endtask

    task automatic queue_random_phase(input int count);
        logic [31:0] stamp;
        logic [4:0]  bits;
        int          r;
        stamp = next_stamp;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                stamp += $urandom_range(0, 2 * int'(cfg_period) + 3);
            end else if (r < 80) begin
                stamp += $urandom_range(0, 3);
            end else if (r < 90) begin
                stamp = $urandom;
            end else begin
                stamp = 32'hFFFF_FF00 + $urandom_range(0, 255);
            end
            if ($urandom_range(0, 1) == 0) begin
                bits = line_shapes[$urandom_range(0, 9)];
            end else begin
                bits = $urandom_range(0, 31);
            end
            push_sample(bits, stamp);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_gap = 0;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        idle_on = 1'b0;
        next_stamp = '0;
        samples_accepted = 0;
        pairs_checked = 0;
        rate_refreshes = 0;
        settings_used = 1;
        mismatches = 0;
        cfg_prop = lfpd_pkg::PROP_GAIN_RST;
        cfg_deriv = lfpd_pkg::DERIV_GAIN_RST;
        cfg_base_right = lfpd_pkg::BASE_RIGHT_RST;
        cfg_base_left = lfpd_pkg::BASE_LEFT_RST;
        cfg_max = lfpd_pkg::MAX_SPEED_RST;
        cfg_period = lfpd_pkg::UPDATE_PERIOD_RST;
        last_refresh_ms = '0;
        latched_error = 0;
        error_slope_q16 = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: lost line at time zero, each sensor alone, priority
        // among several lit sensors, elapsed equal to the period, and the wrap.
        push_sample(5'b00000, 32'd0);
        push_sample(5'b00100, 32'd101);
        push_sample(5'b00010, 32'd250);
        push_sample(5'b01000, 32'd400);
        push_sample(5'b10000, 32'd550);
        push_sample(5'b00001, 32'd700);
        push_sample(5'b11111, 32'd701);
        push_sample(5'b11011, 32'd702);
        push_sample(5'b11001, 32'd900);
        push_sample(5'b10001, 32'd1001);
        push_sample(5'b00000, 32'd1101);
        push_sample(5'b00000, 32'd1102);
        push_sample(5'b00010, 32'hFFFF_FFF0);
        push_sample(5'b10000, 32'h0000_0080);
        push_sample(5'b00001, 32'hFFFF_FFFF);
        push_sample(5'b00100, 32'h0000_0000);
        wait_drained();

        // Zero period with the clamp below the base: the rate refreshes on
        // every millisecond and swings by the largest error steps.
        program_drive(0, 255, 200, 200, 100, 0);
        push_sample(5'b10000, next_stamp + 1);
        push_sample(5'b00000, next_stamp + 1);
        push_sample(5'b10000, next_stamp + 1);
        push_sample(5'b00001, next_stamp + 1);
        push_sample(5'b00001, next_stamp);
        push_sample(5'b00000, next_stamp + 1);
        push_sample(5'b00100, next_stamp + 1);
        push_sample(5'b01000, next_stamp + 2);
        wait_drained();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                1: program_drive(255, 255, 255, 255, 255, 65535);
                2: program_drive(0, 0, 0, 0, 0, 0);
                3: program_drive(130, 60, 155, 155, 230, 100);
                5: program_drive($urandom_range(0, 20), $urandom_range(0, 255),
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 255, $urandom_range(0, 200));
                default: program_drive($urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 65535));
            endcase
            idle_on = (phase % 3 != 2);
            queue_random_phase(150);
            wait_drained();
        end

        if (expected_speeds.size() != 0) begin
            $error("%0d speed words never arrived", expected_speeds.size());
            mismatches++;
        end
        $display("Drove %0d sensor words under %0d register settings, %0d rate refreshes.",
                 samples_accepted, settings_used, rate_refreshes);
        $display("Checked %0d speed pairs, %0d mismatching fields.", pairs_checked, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lfpd_pkg.sv
hdl/line_follower_pd_drive.sv
verif/line_follower_pd_drive_tb.sv
